// File: rtl/sac_pkg.sv
// Shared types and constants for the set-associative cache with prefetch.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package sac_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LRU = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_COUNT  = 3'd4;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SCAN,
		ST_UPDATE,
		ST_NEXT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic load;
		logic scan;
		logic update;
		logic advance;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_way;
		logic stop;
	} status_t;

endpackage

// File: rtl/sac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sac_ctrl.sv
// Controller state machine for the cache: sequences read, way scan, update and prefetch.
// Depends on sac_pkg.
`timescale 1ns / 1ps

module sac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sac_pkg::status_t status,
	output sac_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	import sac_pkg::*;

	state_t state_q, state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_next = ST_READ;
			ST_READ:   state_next = ST_LOAD;
			ST_LOAD:   state_next = ST_SCAN;
			ST_SCAN:   if (status.last_way) state_next = ST_UPDATE;
			ST_UPDATE: state_next = status.stop ? ST_DONE : ST_NEXT;
			ST_NEXT:   state_next = ST_READ;
			ST_DONE:   state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.start = start;
			end
			ST_READ:   ;
			ST_LOAD:   cmd.load = 1'b1;
			ST_SCAN:   cmd.scan = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_NEXT:   cmd.advance = 1'b1;
			ST_DONE:   done = 1'b1;
			default:   ;
		endcase
	end

endmodule

// File: rtl/sac_dpath.sv
// Datapath for the cache: configuration, address split, set row buffer, way scan,
// victim choice, use stamp counter and result registers. Depends on sac_pkg, sac_ram.
`timescale 1ns / 1ps

module sac_dpath #(
	parameter int MAX_SETS     = 256,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 48,
	parameter int PREFETCH_MAX = 15,
	parameter int STAMP_WIDTH  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             op,
	input  logic [ADDR_WIDTH-1:0]            address,
	input  sac_pkg::cmd_t                    cmd,
	output sac_pkg::status_t                 status,
	output logic                             hit,
	output logic [4:0]                       reads_caused,
	output logic                             write_counted,
	output logic                             stamp_saturated
);

	import sac_pkg::*;

	localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int ROWS   = 1 << SB_MAX;
	localparam int IDX_W  = (SB_MAX > 0) ? SB_MAX : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int PF_W   = (PREFETCH_MAX > 0) ? $clog2(PREFETCH_MAX + 1) : 1;
	localparam int LW     = 1 + ADDR_WIDTH + STAMP_WIDTH;
	localparam int ROW_W  = MAX_WAYS * LW;

	// Configuration registers.
	logic                  lru_q;
	logic [CFG_DATA_W-1:0] set_bits_q, way_count_q, block_bits_q, pf_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lru_q        <= 1'b0;
			set_bits_q   <= '0;
			way_count_q  <= CFG_DATA_W'(1);
			block_bits_q <= CFG_DATA_W'(6);
			pf_count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REPLACEMENT_LRU: lru_q        <= cfg_wdata[0];
				REG_SET_BITS:        set_bits_q   <= cfg_wdata;
				REG_WAY_COUNT:       way_count_q  <= cfg_wdata;
				REG_BLOCK_BITS:      block_bits_q <= cfg_wdata;
				REG_PREFETCH_COUNT:  pf_count_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective geometry after clamping.
	logic [CFG_DATA_W-1:0] sb_eff;
	logic [WAY_W-1:0]      way_last;
	logic [PF_W-1:0]       pf_eff;
	int unsigned           ways_n;

	always_comb begin
		sb_eff = (32'(set_bits_q) > SB_MAX) ? CFG_DATA_W'(SB_MAX) : set_bits_q;
		ways_n = 32'(way_count_q);
		if (ways_n == 0) ways_n = 1;
		if (ways_n > MAX_WAYS) ways_n = MAX_WAYS;
		way_last = WAY_W'(ways_n - 1);
		pf_eff = (32'(pf_count_q) > PREFETCH_MAX) ? PF_W'(PREFETCH_MAX) : PF_W'(pf_count_q);
	end

	// Current access address and the next prefetch address.
	logic [ADDR_WIDTH-1:0] addr_q, addr_new, blk, tag_new;
	logic [IDX_W-1:0]      set_new;

	always_comb begin
		if (cmd.start) begin
			addr_new = address;
		end else begin
			addr_new = addr_q + (ADDR_WIDTH'(1) << block_bits_q);
		end
		blk     = addr_new >> block_bits_q;
		set_new = IDX_W'(blk & ((ADDR_WIDTH'(1) << sb_eff) - ADDR_WIDTH'(1)));
		tag_new = blk >> sb_eff;
	end

	logic [IDX_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.advance) begin
			addr_q <= addr_new;
			set_q  <= set_new;
			tag_q  <= tag_new;
		end
	end

	// Set row storage; a row never written reads as all zero.
	logic [ROW_W-1:0] rdata, wdata, row_q;
	logic [ROWS-1:0]  rowv_q;

	sac_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (set_q),
		.wdata (wdata),
		.raddr (set_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_q <= '0;
		end else if (cmd.update) begin
			rowv_q[set_q] <= 1'b1;
		end
	end

	// Fields of the way under scan.
	logic [WAY_W-1:0]       way_q, vict_q;
	logic [LW-1:0]          cur_line;
	logic [STAMP_WIDTH-1:0] cur_stamp, min_q, cnt_q;
	logic                   cur_match, found_q, demand_q;

	assign cur_line  = row_q[way_q*LW +: LW];
	assign cur_stamp = cur_line[STAMP_WIDTH-1:0];
	assign cur_match = cur_line[LW-1] && (cur_line[LW-2:STAMP_WIDTH] == tag_q);

	// Write data: the row with the victim replaced on a miss.
	for (genvar w = 0; w < MAX_WAYS; w++) begin : g_wr
		assign wdata[w*LW +: LW] = (!found_q && vict_q == WAY_W'(w))
			? {1'b1, tag_q, cnt_q} : row_q[w*LW +: LW];
	end

	// Stamp taken on a refresh or a fill.
	logic take;
	assign take = (cmd.scan && cur_match && lru_q && demand_q) || (cmd.update && !found_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= STAMP_WIDTH'(1);
		end else if (take && cnt_q != '1) begin
			cnt_q <= cnt_q + STAMP_WIDTH'(1);
		end
	end

	// Row buffer, scan and victim tracking.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q   <= rowv_q[set_q] ? rdata : '0;
			way_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (cur_match) begin
				found_q <= 1'b1;
				if (lru_q && demand_q) begin
					row_q[way_q*LW +: STAMP_WIDTH] <= cnt_q;
				end
			end
			if (way_q == '0 || cur_stamp < min_q) begin
				min_q  <= cur_stamp;
				vict_q <= way_q;
			end
			way_q <= way_q + WAY_W'(1);
		end
	end

	// Per-transaction bookkeeping and results.
	logic [PF_W-1:0] pf_left_q;
	logic [4:0]      reads_q;
	logic            hit_q, op_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q      <= op;
			demand_q  <= 1'b1;
			pf_left_q <= pf_eff;
			reads_q   <= '0;
		end else begin
			if (cmd.update) begin
				if (!found_q) reads_q <= reads_q + 5'd1;
				if (demand_q) hit_q <= found_q;
			end
			if (cmd.advance) begin
				demand_q  <= 1'b0;
				pf_left_q <= pf_left_q - PF_W'(1);
			end
		end
	end

	assign status.last_way = (way_q == way_last);
	assign status.stop     = (demand_q && found_q) || (pf_left_q == '0);

	assign hit             = hit_q;
	assign reads_caused    = reads_q;
	assign write_counted   = op_q;
	assign stamp_saturated = (cnt_q == '1);

endmodule

// File: rtl/set_assoc_cache_with_prefetch.sv
// Top level of the set-associative cache with FIFO/LRU replacement and next-line prefetch.
// Depends on sac_pkg, sac_ctrl and sac_dpath.
//
//  Channel   Handshake              Payload
//  access    start / busy           op, address
//  result    done (one-cycle)       hit, reads_caused, write_counted, stamp_saturated
//  config    cfg_we                 cfg_idx, cfg_wdata
//
// Each looked-up block passes through the row read, the load, the way scan (one way per
// cycle) and then the row write-back; each prefetch adds an advance step before its block.
// A transaction looks up the demand block, then up to the configured prefetch count after it.
// Reset clears control state and valid rows at once; no clearing pass is needed.
// The result strobe cannot be stalled.
`timescale 1ns / 1ps

module set_assoc_cache_with_prefetch #(
	parameter int MAX_SETS     = 256,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 48,
	parameter int PREFETCH_MAX = 15,
	parameter int STAMP_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [ADDR_WIDTH-1:0]          address,
	output logic                           done,
	output logic                           hit,
	output logic [4:0]                     reads_caused,
	output logic                           write_counted,
	output logic                           stamp_saturated
);

	import sac_pkg::*;

	cmd_t    cmd;
	status_t status;

	sac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sac_dpath #(
		.MAX_SETS     (MAX_SETS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH),
		.PREFETCH_MAX (PREFETCH_MAX),
		.STAMP_WIDTH  (STAMP_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.op              (op),
		.address         (address),
		.cmd             (cmd),
		.status          (status),
		.hit             (hit),
		.reads_caused    (reads_caused),
		.write_counted   (write_counted),
		.stamp_saturated (stamp_saturated)
	);

	// An accepted transaction makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// The result strobe lasts one cycle and the block is idle after it.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not a single cycle");

	// A demand hit causes no memory reads.
	a_hit_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> reads_caused == 5'd0)
		else $error("hit reported with memory reads");

endmodule
